// ----- sv/rogs_pkg.sv -----
// ----------------------------------------------------------------------------
// rogs_pkg
// Types and constants shared by the overbright gamma scaler modules.
// ----------------------------------------------------------------------------
package rogs_pkg;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned FactW    = 12;
  localparam int unsigned FracW    = 8;
  localparam int unsigned ProdW    = ChanW + FactW;
  localparam int unsigned DivW     = ProdW + ChanW;
  localparam int unsigned DsrW     = ProdW + ChanW - 1;
  localparam int unsigned NumCells = ChanW;
  localparam int unsigned NumChan  = 3;

  localparam logic [ChanW-1:0] ChanMax    = 8'd255;
  localparam logic [ProdW-1:0] OverLimit  = ProdW'(ChanMax) << FracW;
  localparam logic [FactW-1:0] GammaReset = 12'd256;

  typedef struct packed {
    logic [ChanW-1:0] red_in;
    logic [ChanW-1:0] green_in;
    logic [ChanW-1:0] blue_in;
    logic             last_pixel;
  } pix_in_t;

  typedef struct packed {
    logic [ChanW-1:0] red_out;
    logic [ChanW-1:0] green_out;
    logic [ChanW-1:0] blue_out;
    logic             last_out;
  } pix_out_t;

  typedef struct packed {
    logic [NumChan-1:0][DivW-1:0]  rem;
    logic [DsrW-1:0]               dsr;
    logic [NumChan-1:0][ChanW-1:0] quo;
    logic [NumChan-1:0][ChanW-1:0] trunc;
    logic                          over;
    logic                          last;
  } cell_t;

endpackage

// ----- sv/rogs_front.sv -----
// ----------------------------------------------------------------------------
// rogs_front
// Scales the three channels by the factor, finds the largest product and
// prepares the dividends for the divider chain.
// ----------------------------------------------------------------------------
module rogs_front import rogs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [FactW-1:0] gamma_i,
  input  logic             valid_i,
  output logic             ready_o,
  input  pix_in_t          data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output cell_t            data_o
);

  logic                          s0_valid_q;
  logic [NumChan-1:0][ProdW-1:0] prod_q;
  logic                          last_q;
  logic                          s1_valid_q;
  cell_t                         s1_q;
  cell_t                         s1_d;
  logic                          s0_ready;
  logic                          s1_ready;
  logic [ChanW-1:0]              chan [NumChan];
  logic [ProdW-1:0]              max_prod;

  assign s1_ready = ~s1_valid_q | ready_i;
  assign s0_ready = ~s0_valid_q | s1_ready;
  assign ready_o  = s0_ready;

  assign chan[0] = data_i.red_in;
  assign chan[1] = data_i.green_in;
  assign chan[2] = data_i.blue_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      if (s0_ready) begin
        s0_valid_q <= valid_i;
      end
      if (s1_ready) begin
        s1_valid_q <= s0_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_ready && valid_i) begin
      for (int i = 0; i < NumChan; i++) begin
        prod_q[i] <= ProdW'(chan[i]) * ProdW'(gamma_i);
      end
      last_q <= data_i.last_pixel;
    end
    if (s1_ready && s0_valid_q) begin
      s1_q <= s1_d;
    end
  end

  always_comb begin
    max_prod = prod_q[0];
    if (prod_q[1] > max_prod) begin
      max_prod = prod_q[1];
    end
    if (prod_q[2] > max_prod) begin
      max_prod = prod_q[2];
    end
    for (int i = 0; i < NumChan; i++) begin
      s1_d.rem[i]   = (DivW'(prod_q[i]) << ChanW) - DivW'(prod_q[i]);
      s1_d.quo[i]   = '0;
      s1_d.trunc[i] = prod_q[i][FracW +: ChanW];
    end
    s1_d.dsr  = DsrW'(max_prod) << (NumCells - 1);
    s1_d.over = max_prod > OverLimit;
    s1_d.last = last_q;
  end

  assign valid_o = s1_valid_q;
  assign data_o  = s1_q;

endmodule

// ----- sv/rogs_div_cell.sv -----
// ----------------------------------------------------------------------------
// rogs_div_cell
// One restoring division step for all three channels, producing one
// quotient bit per channel and halving the divisor for the next cell.
// ----------------------------------------------------------------------------
module rogs_div_cell import rogs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  cell_t data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output cell_t data_o
);

  logic  valid_q;
  cell_t data_q;
  cell_t data_d;
  logic  ge;

  assign ready_o = ~valid_q | ready_i;

  always_comb begin
    data_d = data_i;
    ge     = 1'b0;
    for (int i = 0; i < NumChan; i++) begin
      ge = data_i.rem[i] >= DivW'(data_i.dsr);
      if (ge) begin
        data_d.rem[i] = data_i.rem[i] - DivW'(data_i.dsr);
      end
      data_d.quo[i] = {data_i.quo[i][ChanW-2:0], ge};
    end
    data_d.dsr = data_i.dsr >> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- sv/rgb_overbright_gamma_scale.sv -----
// ----------------------------------------------------------------------------
// rgb_overbright_gamma_scale
// Brightness scaling of RGB pixels with hue-preserving overbright clamping.
// ----------------------------------------------------------------------------
// Pixels enter on the in channel and leave on the out channel, both
// valid/ready; a word moves when valid and ready are high at a clock edge.
// Each channel is multiplied by the Q4.8 factor written through cfg_we_i and
// cfg_wdata_i. When the largest product exceeds 255.0, every channel becomes
// floor(p * 255 / max); otherwise it is the integer part of its product.
// The factor should only be written while no pixel is in flight.
// A pixel passes through one multiply stage, one stage that finds the
// maximum, and a row of eight divider cells that each settle one quotient
// bit for all three channels.
// Throughput is one pixel per clock while the receiver does not stall.
// Every stage has its own ready, so the block keeps accepting pixels while
// the receiver stalls until all ten stages hold a pixel, and empty stages
// close up behind a stalled output.
// Reset empties all stages and sets the factor to 1.0.
// ----------------------------------------------------------------------------
module rgb_overbright_gamma_scale import rogs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [FactW-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pix_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output pix_out_t         out_data_o
);

  logic [FactW-1:0] gamma_q;
  logic             valid  [NumCells+1];
  logic             ready  [NumCells+1];
  cell_t            data   [NumCells+1];
  cell_t            result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q <= GammaReset;
    end else if (cfg_we_i) begin
      gamma_q <= cfg_wdata_i;
    end
  end

  rogs_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .gamma_i (gamma_q),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (valid[0]),
    .ready_i (ready[0]),
    .data_o  (data[0])
  );

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    rogs_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[k]),
      .ready_o (ready[k]),
      .data_i  (data[k]),
      .valid_o (valid[k+1]),
      .ready_i (ready[k+1]),
      .data_o  (data[k+1])
    );
  end

  assign ready[NumCells] = out_ready_i;
  assign result          = data[NumCells];
  assign out_valid_o     = valid[NumCells];

  assign out_data_o.red_out   = result.over ? result.quo[0] : result.trunc[0];
  assign out_data_o.green_out = result.over ? result.quo[1] : result.trunc[1];
  assign out_data_o.blue_out  = result.over ? result.quo[2] : result.trunc[2];
  assign out_data_o.last_out  = result.last;

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RGB overbright gamma scaler.
// ----------------------------------------------------------------------------
// Pixels are queued by the stimulus process and handed to the block by a
// driver on the falling edge. Each accepted word is scaled by a local copy
// of the brightness factor and kept in order. A monitor compares each
// output word with the oldest kept pixel. The factor is rewritten only
// while the block is empty. Sender and receiver stall at random, with one
// long receiver hold so that the pipeline fills up.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import rogs_pkg::*;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned HoldCycles    = 80;
  localparam int unsigned NumPhases     = 15;
  localparam int unsigned PhaseItems    = 107;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [FactW-1:0] cfg_wdata_i = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  pix_in_t          in_data_i   = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  pix_out_t         out_data_o;

  pix_in_t          pixel_q[$];
  pix_out_t         scaled_q[$];
  logic [FactW-1:0] factor_model = GammaReset;
  int unsigned      queued_cnt   = 0;
  int unsigned      accepted_cnt = 0;
  int unsigned      error_cnt    = 0;
  int unsigned      quiet_cnt    = 0;
  int unsigned      send_idle    = 0;
  int unsigned      recv_idle    = 0;
  int unsigned      hold_req     = 0;
  int unsigned      hold_seen    = 0;
  int unsigned      hold_left    = 0;
  bit               in_fire      = 1'b0;

  always #4 clk_i = ~clk_i;

  rgb_overbright_gamma_scale DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  function automatic logic [ChanW-1:0] scale_chan(bit [31:0] prod, bit [31:0] peak);
    bit [31:0] q;
    if (peak > 32'(255 * 256)) begin
      q = (prod * 32'd255) / peak;
    end else begin
      q = prod >> 8;
    end
    return q[ChanW-1:0];
  endfunction

  function automatic pix_out_t scale_pixel(pix_in_t px, logic [FactW-1:0] factor);
    bit [31:0] pr;
    bit [31:0] pg;
    bit [31:0] pb;
    bit [31:0] peak;
    pix_out_t  res;
    pr   = 32'(px.red_in) * 32'(factor);
    pg   = 32'(px.green_in) * 32'(factor);
    pb   = 32'(px.blue_in) * 32'(factor);
    peak = pr;
    if (pg > peak) peak = pg;
    if (pb > peak) peak = pb;
    res.red_out   = scale_chan(pr, peak);
    res.green_out = scale_chan(pg, peak);
    res.blue_out  = scale_chan(pb, peak);
    res.last_out  = px.last_pixel;
    return res;
  endfunction

  function automatic logic [ChanW-1:0] rand_chan();
    case ($urandom_range(7))
      0: return '0;
      1: return ChanMax;
      default: return ChanW'($urandom_range(0, 255));
    endcase
  endfunction

  // Input side: accept on the rising edge, drive on the falling edge.
  always @(posedge clk_i) begin
    in_fire = in_valid_i && in_ready_o;
    if (in_fire) begin
      scaled_q.push_back(scale_pixel(in_data_i, factor_model));
      accepted_cnt++;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_fire) begin
      if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pixel_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output side: the receiver stalls at random or for one long hold.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen   <= hold_req;
      hold_left   <= HoldCycles;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    pix_out_t want;
    if (out_valid_o && out_ready_i) begin
      if (scaled_q.size() == 0) begin
        $display("%0t: unexpected output word %h", $time, out_data_o);
        error_cnt++;
      end else begin
        want = scaled_q.pop_front();
        if (out_data_o.red_out !== want.red_out) begin
          $display("%0t: red expected %0d actual %0d",
                   $time, want.red_out, out_data_o.red_out);
          error_cnt++;
        end
        if (out_data_o.green_out !== want.green_out) begin
          $display("%0t: green expected %0d actual %0d",
                   $time, want.green_out, out_data_o.green_out);
          error_cnt++;
        end
        if (out_data_o.blue_out !== want.blue_out) begin
          $display("%0t: blue expected %0d actual %0d",
                   $time, want.blue_out, out_data_o.blue_out);
          error_cnt++;
        end
        if (out_data_o.last_out !== want.last_out) begin
          $display("%0t: last expected %0b actual %0b",
                   $time, want.last_out, out_data_o.last_out);
          error_cnt++;
        end
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cnt = 0;
    end else begin
      quiet_cnt++;
      if (quiet_cnt >= WatchdogLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet_cnt);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic add_pixel(logic [ChanW-1:0] r, logic [ChanW-1:0] g,
                           logic [ChanW-1:0] b, logic last);
    pix_in_t px;
    px.red_in     = r;
    px.green_in   = g;
    px.blue_in    = b;
    px.last_pixel = last;
    pixel_q.push_back(px);
    queued_cnt++;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (accepted_cnt != queued_cnt || scaled_q.size() != 0);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic write_factor(logic [FactW-1:0] factor);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= factor;
    @(negedge clk_i);
    cfg_we_i     <= 1'b0;
    factor_model  = factor;
    @(posedge clk_i);
  endtask

  initial begin
    logic [FactW-1:0] factor;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset factor of 1.0: a full channel lands exactly on 255.0.
    send_idle = 34;
    recv_idle = 62;
    add_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    add_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    add_pixel(8'd255, 8'd0, 8'd128, 1'b0);
    add_pixel(8'd170, 8'd85, 8'd1, 1'b1);
    write_factor(12'd0);
    add_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    add_pixel(8'd85, 8'd170, 8'd15, 1'b0);
    write_factor(12'd4095);
    add_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    add_pixel(8'd0, 8'd255, 8'd0, 1'b1);
    add_pixel(8'd0, 8'd0, 8'd255, 1'b0);
    add_pixel(8'd1, 8'd1, 8'd1, 1'b0);
    add_pixel(8'd1, 8'd0, 8'd0, 1'b1);
    add_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    write_factor(12'd257);
    add_pixel(8'd255, 8'd254, 8'd1, 1'b0);
    add_pixel(8'd254, 8'd254, 8'd254, 1'b1);
    write_factor(12'd255);
    add_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    write_factor(12'd512);
    add_pixel(8'd128, 8'd127, 8'd64, 1'b1);
    add_pixel(8'd127, 8'd126, 8'd0, 1'b0);

    for (int p = 0; p < NumPhases; p++) begin
      case ($urandom_range(7))
        0: factor = '0;
        1: factor = 12'd4095;
        2: factor = GammaReset;
        3: factor = 12'd255;
        4: factor = 12'd257;
        5: factor = FactW'($urandom_range(0, 255));
        default: factor = FactW'($urandom_range(0, 4095));
      endcase
      write_factor(factor);
      if (p < 5) begin
        send_idle = 34;
        recv_idle = 62;
      end else if (p < 10) begin
        send_idle = 62;
        recv_idle = 34;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      for (int i = 0; i < PhaseItems; i++) begin
        add_pixel(rand_chan(), rand_chan(), rand_chan(), $urandom_range(15) == 0);
      end
      if (p == 12) begin
        hold_req++;
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
